// File: hdl/text_console_writer_defines.svh
// Assertion macros shared by the text console writer modules.
// No dependencies; included by the files that carry assertions.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tcw_pkg.sv
// Shared constants, codes and types of the text console writer.
// No dependencies; used by every other file of the block but tcw_ram and the macros header.
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int TOTAL   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(TOTAL);
    localparam int CCOL_W  = $clog2(COLUMNS);
    localparam int CROW_W  = $clog2(ROWS);
    localparam int MARK_W  = $clog2(COLUMNS + 1);

    // Field widths of the request and response channels.
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int FCOL_W = 7;
    localparam int FROW_W = 5;
    localparam int CLR_W  = 4;
    localparam int ATTR_W = 2 * CLR_W;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // Special characters.
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd32;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b1;
    localparam logic [CLR_W-1:0] BG_RESET = 4'd1;
    localparam logic [CLR_W-1:0] FG_RESET = 4'd14;

    // Classified command kinds.
    typedef enum logic [2:0] {
        K_CHAR,
        K_NEWLINE,
        K_BACKSPACE,
        K_READ,
        K_CLEAR,
        K_NOP
    } t_kind;

    // One classified request as it sits in the queue.
    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_code;
        logic              at_cursor;
        logic              typing;
        logic [CCOL_W-1:0] col;
        logic [CROW_W-1:0] row;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    // Handshake between a producer and the queue, or the queue and a consumer.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

endpackage

// File: hdl/tcw_if.sv
// Request and response channel interfaces of the text console writer.
// Depends on tcw_pkg for the field widths.

// Request channel: one console operation.
interface tcw_req_if;
    logic                      valid;
    logic                      ready;
    logic [tcw_pkg::OP_W-1:0]   operation;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic                      at_cursor;
    logic [tcw_pkg::FCOL_W-1:0] column;
    logic [tcw_pkg::FROW_W-1:0] line;
    logic                      typing;

    modport source (output valid, operation, char_code, at_cursor, column, line, typing,
                    input ready);
    modport sink   (input valid, operation, char_code, at_cursor, column, line, typing,
                    output ready);
endinterface

// Response channel: cell contents and cursor after the operation.
interface tcw_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [tcw_pkg::CHAR_W-1:0] cell_char;
    logic [tcw_pkg::ATTR_W-1:0] cell_attr;
    logic [tcw_pkg::FCOL_W-1:0] cursor_col;
    logic [tcw_pkg::FROW_W-1:0] cursor_row;

    modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row,
                    input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row,
                    output ready);
endinterface

// File: hdl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the character cell store.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tcw_front.sv
// Front end: accepts requests, classifies them and resolves explicit cell addresses.
// Depends on tcw_pkg and tcw_req_if; feeds tcw_queue.
module tcw_front (
    tcw_req_if.sink               i_req,
    input  logic                  i_queue_full,
    output tcw_pkg::t_cmd_req     o_push
);

    tcw_pkg::t_kind                kind;
    logic [tcw_pkg::CCOL_W-1:0]    col;
    logic [tcw_pkg::CROW_W-1:0]    row;

    // Classify the operation, splitting puts into newline, backspace and ordinary characters.
    always_comb begin
        kind = tcw_pkg::K_NOP;
        unique case (i_req.operation)
            tcw_pkg::OP_PUT: begin
                priority if (i_req.char_code == tcw_pkg::CHAR_NEWLINE) begin
                    kind = tcw_pkg::K_NEWLINE;
                end else if (i_req.char_code == tcw_pkg::CHAR_BACKSPACE) begin
                    kind = tcw_pkg::K_BACKSPACE;
                end else begin
                    kind = tcw_pkg::K_CHAR;
                end
            end
            tcw_pkg::OP_READ:  kind = tcw_pkg::K_READ;
            tcw_pkg::OP_CLEAR: kind = tcw_pkg::K_CLEAR;
            tcw_pkg::OP_NOP:   kind = tcw_pkg::K_NOP;
        endcase
    end

    // Clamp an explicit position to the screen.
    always_comb begin
        if (32'(i_req.column) >= tcw_pkg::COLUMNS) begin
            col = tcw_pkg::CCOL_W'(tcw_pkg::COLUMNS - 1);
        end else begin
            col = tcw_pkg::CCOL_W'(i_req.column);
        end
        if (32'(i_req.line) >= tcw_pkg::ROWS) begin
            row = tcw_pkg::CROW_W'(tcw_pkg::ROWS - 1);
        end else begin
            row = tcw_pkg::CROW_W'(i_req.line);
        end
    end

    // Build the queue entry; the cell index is row * COLUMNS + column.
    always_comb begin
        o_push.valid         = i_req.valid && !i_queue_full;
        o_push.cmd.kind      = kind;
        o_push.cmd.char_code = i_req.char_code;
        o_push.cmd.at_cursor = i_req.at_cursor;
        o_push.cmd.typing    = i_req.typing;
        o_push.cmd.col       = col;
        o_push.cmd.row       = row;
        o_push.cmd.addr      = tcw_pkg::ADDR_W'(32'(row) * tcw_pkg::COLUMNS + 32'(col));
    end

    assign i_req.ready = !i_queue_full;

endmodule

// File: hdl/tcw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tcw_pkg for the command type and the depth.
module tcw_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcw_pkg::t_cmd_req     i_push,
    output logic                  o_full,
    output tcw_pkg::t_cmd_req     o_head,
    input  logic                  i_pop
);

    localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

    tcw_pkg::t_cmd     r_slot [tcw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              push, pop;

    assign o_full = (32'(r_count) == tcw_pkg::QUEUE_DEPTH);
    assign push   = i_push.valid && !o_full;
    assign pop    = i_pop && (r_count != '0);

    // Pointer and fill-level update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (32'(r_wr_ptr) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];

endmodule

// File: hdl/tcw_back.sv
// Back end: executes queued commands on the cell store, keeps cursor and mark, scrolls and clears.
// Depends on tcw_pkg, tcw_rsp_if, tcw_ram and the assertion macros header.
`include "text_console_writer_defines.svh"

module tcw_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0] i_attr,
    input  tcw_pkg::t_cmd_req          i_head,
    output logic                       o_pop,
    tcw_rsp_if.source                  o_rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_COPY = 2'd2;
    localparam logic [1:0] ST_FILL = 2'd3;

    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int CCOL_W = tcw_pkg::CCOL_W;
    localparam int CROW_W = tcw_pkg::CROW_W;
    localparam int MARK_W = tcw_pkg::MARK_W;

    logic [1:0]                 r_state, n_state;
    logic [CROW_W-1:0]          r_crow, n_crow;
    logic [CCOL_W-1:0]          r_ccol, n_ccol;
    logic [MARK_W-1:0]          r_mark, n_mark;
    logic [ADDR_W-1:0]          r_idx, n_idx;
    logic                       r_cp_valid, n_cp_valid;
    logic [ADDR_W-1:0]          r_cp_addr, n_cp_addr;
    logic                       r_out_valid, n_out_valid;
    logic [tcw_pkg::CHAR_W-1:0] r_out_char, n_out_char;
    logic [tcw_pkg::ATTR_W-1:0] r_out_attr, n_out_attr;
    logic [CCOL_W-1:0]          r_out_col, n_out_col;
    logic [CROW_W-1:0]          r_out_row, n_out_row;

    logic                       out_free, go, out_ld;
    tcw_pkg::t_cmd              cmd;
    logic [ADDR_W-1:0]          cur_addr, pos_addr;
    logic [CCOL_W-1:0]          pos_col;
    logic [CROW_W-1:0]          pos_row;
    logic [CROW_W:0]            row_inc;
    logic [tcw_pkg::CELL_W-1:0] blank;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    // Cell store.
    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::TOTAL)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Operand selection: cursor cell or the explicit cell from the front end.
    assign cmd      = i_head.cmd;
    assign cur_addr = ADDR_W'(32'(r_crow) * tcw_pkg::COLUMNS + 32'(r_ccol));
    assign pos_addr = cmd.at_cursor ? cur_addr : cmd.addr;
    assign pos_col  = cmd.at_cursor ? r_ccol : cmd.col;
    assign pos_row  = cmd.at_cursor ? r_crow : cmd.row;
    assign row_inc  = {1'b0, pos_row} + (CROW_W + 1)'(1);
    assign blank    = {i_attr, tcw_pkg::CHAR_BLANK};

    // A command starts only when its result has somewhere to go.
    assign out_free = !r_out_valid || o_rsp.ready;
    assign go       = (r_state == ST_IDLE) && i_head.valid && out_free;
    assign o_pop    = go;

    // Command sequencer.
    always_comb begin
        n_state    = r_state;
        n_crow     = r_crow;
        n_ccol     = r_ccol;
        n_mark     = r_mark;
        n_idx      = r_idx;
        n_cp_valid = 1'b0;
        n_cp_addr  = r_idx;
        out_ld     = 1'b0;
        n_out_char = '0;
        n_out_attr = '0;
        ram_we     = 1'b0;
        ram_waddr  = pos_addr;
        ram_wdata  = blank;
        ram_raddr  = pos_addr;

        unique case (r_state)
            ST_IDLE: begin
                if (go) begin
                    out_ld = 1'b1;
                    unique case (cmd.kind)
                        tcw_pkg::K_CHAR: begin
                            ram_we    = 1'b1;
                            ram_wdata = {i_attr, cmd.char_code};
                            if (32'(pos_col) == tcw_pkg::COLUMNS - 1) begin
                                n_ccol = '0;
                                n_crow = CROW_W'(row_inc);
                            end else begin
                                n_ccol = pos_col + CCOL_W'(1);
                                n_crow = pos_row;
                            end
                            if (!cmd.typing) begin
                                n_mark = MARK_W'(n_ccol) + MARK_W'(1);
                            end
                        end
                        tcw_pkg::K_NEWLINE: begin
                            n_ccol = '0;
                            n_crow = CROW_W'(row_inc);
                        end
                        tcw_pkg::K_BACKSPACE: begin
                            // Blank the previous cell only off cell 0, and there only on the top row past its start
                            // or once the mark is set.
                            if ((pos_addr != '0) &&
                                (((pos_row == '0) && (pos_col != '0)) || (r_mark != '0))) begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_addr - ADDR_W'(1);
                                if (pos_col != '0) begin
                                    n_ccol = pos_col - CCOL_W'(1);
                                    n_crow = pos_row;
                                end else begin
                                    n_ccol = CCOL_W'(tcw_pkg::COLUMNS - 1);
                                    n_crow = pos_row - CROW_W'(1);
                                end
                            end
                        end
                        tcw_pkg::K_READ: begin
                            out_ld  = 1'b0;
                            n_state = ST_READ;
                        end
                        tcw_pkg::K_CLEAR: begin
                            out_ld = 1'b0;
                            if (!cmd.typing) begin
                                n_mark = MARK_W'(1);
                            end
                            n_ccol  = '0;
                            n_crow  = '0;
                            n_idx   = '0;
                            n_state = ST_FILL;
                        end
                        tcw_pkg::K_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                    // Moving past the last cell scrolls the screen up by one row.
                    if (((cmd.kind == tcw_pkg::K_CHAR) || (cmd.kind == tcw_pkg::K_NEWLINE)) &&
                        (32'(row_inc) == tcw_pkg::ROWS) &&
                        ((cmd.kind == tcw_pkg::K_NEWLINE) ||
                         (32'(pos_col) == tcw_pkg::COLUMNS - 1))) begin
                        out_ld  = 1'b0;
                        n_ccol  = '0;
                        n_crow  = CROW_W'(tcw_pkg::ROWS - 1);
                        n_idx   = '0;
                        n_state = ST_COPY;
                    end
                end
            end
            ST_READ: begin
                out_ld     = 1'b1;
                n_out_char = ram_rdata[tcw_pkg::CHAR_W-1:0];
                n_out_attr = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                n_state    = ST_IDLE;
            end
            ST_COPY: begin
                // Read one row down, write it back in the following cycle.
                ram_raddr  = ADDR_W'(32'(r_idx) + tcw_pkg::COLUMNS);
                n_cp_valid = 1'b1;
                n_cp_addr  = r_idx;
                if (32'(r_idx) == tcw_pkg::TOTAL - tcw_pkg::COLUMNS - 1) begin
                    n_idx   = ADDR_W'(tcw_pkg::TOTAL - tcw_pkg::COLUMNS);
                    n_state = ST_FILL;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            ST_FILL: begin
                // Any pending copy write goes first, then blanks run to the end.
                if (!r_cp_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    if (32'(r_idx) == tcw_pkg::TOTAL - 1) begin
                        out_ld  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (r_cp_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_addr;
            ram_wdata = ram_rdata;
        end

        n_out_col = n_ccol;
        n_out_row = n_crow;
    end

    // Output register handshake.
    always_comb begin
        if (out_ld) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_crow      <= '0;
            r_ccol      <= '0;
            r_mark      <= '0;
            r_idx       <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crow      <= n_crow;
            r_ccol      <= n_ccol;
            r_mark      <= n_mark;
            r_idx       <= n_idx;
            r_cp_valid  <= n_cp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cp_addr <= n_cp_addr;
        if (out_ld) begin
            r_out_char <= n_out_char;
            r_out_attr <= n_out_attr;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_char  = r_out_char;
    assign o_rsp.cell_attr  = r_out_attr;
    assign o_rsp.cursor_col = tcw_pkg::FCOL_W'(r_out_col);
    assign o_rsp.cursor_row = tcw_pkg::FROW_W'(r_out_row);

    `TCW_ASSERT_IMP(a_pop_when_idle, i_clk, i_rst_n, o_pop, r_state == ST_IDLE, "pop outside idle")
    `TCW_ASSERT_IMP(a_load_free, i_clk, i_rst_n, out_ld, out_free, "result overwrites a waiting one")
    `TCW_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, 1'b1, (32'(r_crow) < tcw_pkg::ROWS) && (32'(r_ccol) < tcw_pkg::COLUMNS), "cursor off screen")
    `TCW_ASSERT_NXT(a_copy_writes, i_clk, i_rst_n, r_state == ST_COPY, r_cp_valid, "copy read without write-back")
    `TCW_ASSERT_NXT(a_read_wait, i_clk, i_rst_n, o_pop && (cmd.kind == tcw_pkg::K_READ), r_state == ST_READ, "read did not wait for data")

endmodule

// File: hdl/text_console_writer.sv
// Text console writer: a screen of ROWS x COLUMNS character cells with cursor, scroll and clear.
// The front end classifies each request and resolves an explicit cell index, a two-entry queue
// decouples it from the back end, which owns the cell memory, the cursor and the last-column
// mark. Requests are taken one per cycle while the queue has room. In the back end a put,
// newline, backspace or no-op completes as it is popped; a read waits for the registered
// memory read first. A put or newline past the last cell scrolls: it copies the rows below up
// through the single read and write port, drains the last copy write and blanks the bottom row.
// A clear blanks every cell. Colours must be written by the user through the configuration
// port only while no request is outstanding; the block itself does not enforce this.
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_queue and tcw_back.
module text_console_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcw_req_if.sink                         i_req,
    tcw_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tcw_pkg::CLR_W-1:0]       i_cfg_data
);

    logic [tcw_pkg::CLR_W-1:0] r_bg, r_fg;
    tcw_pkg::t_cmd_req         push, head;
    logic                      queue_full, pop;

    // Colour registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= tcw_pkg::BG_RESET;
            r_fg <= tcw_pkg::FG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcw_pkg::REG_BACKGROUND: r_bg <= i_cfg_data;
                tcw_pkg::REG_FOREGROUND: r_fg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcw_front u_front (
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    tcw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_attr  ({r_bg, r_fg}),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// File: sim/tb_text_console_writer.sv
// Self-checking testbench of the text console writer: a directed table, then random phases.
// Depends on tcw_pkg, the tcw_req_if and tcw_rsp_if interfaces and text_console_writer.
`timescale 1ns / 100ps

module tb_text_console_writer;

    localparam int QUIET_LIMIT  = 10000;
    localparam int DRAIN_CYCLES = 50;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 75;
    localparam int PRINT_LIMIT  = 100;
    localparam int COLUMNS      = tcw_pkg::COLUMNS;
    localparam int ROWS         = tcw_pkg::ROWS;
    localparam int TOTAL        = tcw_pkg::TOTAL;
    localparam int OP_W         = tcw_pkg::OP_W;
    localparam int CHAR_W       = tcw_pkg::CHAR_W;
    localparam int FCOL_W       = tcw_pkg::FCOL_W;
    localparam int FROW_W       = tcw_pkg::FROW_W;
    localparam int CLR_W        = tcw_pkg::CLR_W;
    localparam int ATTR_W       = tcw_pkg::ATTR_W;
    localparam int CELL_W       = tcw_pkg::CELL_W;
    localparam logic [ATTR_W-1:0] RESET_ATTR = {tcw_pkg::BG_RESET, tcw_pkg::FG_RESET};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic              at_cursor;
        logic [FCOL_W-1:0] column;
        logic [FROW_W-1:0] line;
        logic              typing;
    } t_console_req;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [FCOL_W-1:0] col;
        logic [FROW_W-1:0] row;
    } t_console_rsp;

    typedef struct {
        t_console_req req;
        bit           known;
        t_console_rsp rsp;
    } t_directed_row;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [CLR_W-1:0] cfg_data;

    tcw_req_if req_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow copy of the screen, cursor, mark and colours.
    logic [CELL_W-1:0] screen [TOTAL];
    int cursor = 0;
    int mark = 0;
    logic [CLR_W-1:0] bg_colour = tcw_pkg::BG_RESET;
    logic [CLR_W-1:0] fg_colour = tcw_pkg::FG_RESET;

    t_console_rsp  pending_replies [$];
    t_directed_row directed [$];
    int mismatches = 0;
    int send_calm = 0;
    int ready_calm = 0;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Idle length for either side: mostly short, a few long, with calm stretches.
    function automatic int idle_gap(inout int calm);
        int k;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        k = int'($urandom_range(0, 99));
        if (k < 3) begin
            calm = int'($urandom_range(10, 40));
            return 0;
        end
        if (k < 50) return 0;
        if (k < 85) return int'($urandom_range(1, 3));
        if (k < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [CELL_W-1:0] blank_word();
        return {bg_colour, fg_colour, tcw_pkg::CHAR_BLANK};
    endfunction

    // Cell addressed by a request; explicit positions saturate at the screen edge.
    function automatic int cell_index(input t_console_req r);
        int c;
        int l;
        if (r.at_cursor) return cursor;
        c = (int'(r.column) >= COLUMNS) ? COLUMNS - 1 : int'(r.column);
        l = (int'(r.line) >= ROWS) ? ROWS - 1 : int'(r.line);
        return l * COLUMNS + c;
    endfunction

    // Applies one request to the shadow console and works out its reply.
    task automatic apply_console_op(input t_console_req r, output t_console_rsp reply);
        int pos;
        int row;
        int col;
        logic [CELL_W-1:0] word;
        reply = '0;
        case (r.op)
            tcw_pkg::OP_PUT: begin
                pos = cell_index(r);
                row = pos / COLUMNS;
                col = pos % COLUMNS;
                if (r.ch == tcw_pkg::CHAR_NEWLINE) begin
                    pos = (row + 1) * COLUMNS;
                end else if (r.ch == tcw_pkg::CHAR_BACKSPACE) begin
                    // Backspace only acts off cell 0, on the top row or once a mark is set.
                    if (pos > 0 && ((row == 0 && col > 0) || mark != 0)) begin
                        pos--;
                        screen[pos] = blank_word();
                    end else begin
                        pos = cursor;
                    end
                end else begin
                    screen[pos] = {bg_colour, fg_colour, r.ch};
                    pos++;
                    if (!r.typing) mark = pos % COLUMNS + 1;
                end
                // Passing the last cell scrolls up one row and homes to the bottom row.
                if (pos >= TOTAL) begin
                    for (int i = 0; i < TOTAL - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                    for (int i = TOTAL - COLUMNS; i < TOTAL; i++) screen[i] = blank_word();
                    pos = TOTAL - COLUMNS;
                end
                cursor = pos;
            end
            tcw_pkg::OP_READ: begin
                word = screen[cell_index(r)];
                reply.ch = word[CHAR_W-1:0];
                reply.attr = word[CELL_W-1:CHAR_W];
            end
            tcw_pkg::OP_CLEAR: begin
                for (int i = 0; i < TOTAL; i++) screen[i] = blank_word();
                if (!r.typing) mark = 1;
                cursor = 0;
            end
            default: ;
        endcase
        reply.col = FCOL_W'(cursor % COLUMNS);
        reply.row = FROW_W'(cursor / COLUMNS);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic atc, input int col, input int line, input logic typ,
                           input bit known, input logic [CHAR_W-1:0] e_ch,
                           input logic [ATTR_W-1:0] e_attr, input int e_col, input int e_row);
        t_directed_row d;
        d.req = '{op, ch, atc, FCOL_W'(col), FROW_W'(line), typ};
        d.known = known;
        d.rsp = '{e_ch, e_attr, FCOL_W'(e_col), FROW_W'(e_row)};
        directed.push_back(d);
    endtask

    // Random request: mostly well-formed typing, with raw noise mixed in.
    function automatic t_console_req random_request();
        t_console_req r;
        int k;
        r.op = OP_W'($urandom_range(0, 3));
        r.ch = CHAR_W'($urandom_range(0, 255));
        r.at_cursor = 1'($urandom_range(0, 1));
        r.column = FCOL_W'($urandom_range(0, 127));
        r.line = FROW_W'($urandom_range(0, 31));
        r.typing = 1'($urandom_range(0, 1));
        k = int'($urandom_range(0, 99));
        if (k < 40) begin
            r.op = tcw_pkg::OP_PUT;
            r.at_cursor = 1'b1;
            if ($urandom_range(0, 4) != 0) r.ch = CHAR_W'($urandom_range(32, 126));
        end else if (k < 50) begin
            r.op = tcw_pkg::OP_PUT;
            r.at_cursor = 1'b1;
            r.ch = tcw_pkg::CHAR_NEWLINE;
        end else if (k < 57) begin
            r.op = tcw_pkg::OP_PUT;
            r.at_cursor = 1'b1;
            r.ch = tcw_pkg::CHAR_BACKSPACE;
        end else if (k < 67) begin
            // Explicit put, often on the last cell so that it scrolls.
            r.op = tcw_pkg::OP_PUT;
            r.at_cursor = 1'b0;
            r.column = FCOL_W'($urandom_range(0, COLUMNS - 1));
            r.line = FROW_W'($urandom_range(0, ROWS - 1));
            if ($urandom_range(0, 3) == 0) begin
                r.column = FCOL_W'(COLUMNS - 1);
                r.line = FROW_W'(ROWS - 1);
            end
        end else if (k < 80) begin
            r.op = tcw_pkg::OP_READ;
            r.column = FCOL_W'($urandom_range(0, COLUMNS - 1));
            r.line = FROW_W'($urandom_range(0, ROWS - 1));
        end else if (k < 86) begin
            // Raw explicit position, out of range as often as not.
            r.op = $urandom_range(0, 1) ? tcw_pkg::OP_READ : tcw_pkg::OP_PUT;
            r.at_cursor = 1'b0;
        end else if (k < 90) begin
            r.op = tcw_pkg::OP_NOP;
        end else if (k < 93) begin
            r.op = tcw_pkg::OP_CLEAR;
        end
        return r;
    endfunction

    // Drives one request, waits for its acceptance and queues the reply it must cause.
    task automatic send_request(input t_console_req r, input bit known,
                                input t_console_rsp typed_rsp);
        int gap;
        t_console_rsp e;
        gap = idle_gap(send_calm);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= r.op;
        req_ch.char_code <= r.ch;
        req_ch.at_cursor <= r.at_cursor;
        req_ch.column    <= r.column;
        req_ch.line      <= r.line;
        req_ch.typing    <= r.typing;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        apply_console_op(r, e);
        pending_replies.push_back(known ? typed_rsp : e);
    endtask

    // Writes both colour registers once every reply has come back.
    task automatic write_colours(input logic [CLR_W-1:0] bg, input logic [CLR_W-1:0] fg);
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= tcw_pkg::REG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge clk);
        bg_colour = bg;
        cfg_index <= tcw_pkg::REG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge clk);
        fg_colour = fg;
        cfg_we <= 1'b0;
    endtask

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial begin
        logic [CLR_W-1:0] bg;
        logic [CLR_W-1:0] fg;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= tcw_pkg::OP_NOP;
        req_ch.char_code <= '0;
        req_ch.at_cursor <= 1'b0;
        req_ch.column    <= '0;
        req_ch.line      <= '0;
        req_ch.typing    <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= tcw_pkg::REG_BACKGROUND;
        cfg_data         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Backspace at cell 0 and with no mark set changes nothing.
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 1, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 0, 5, 3, 0, 1, 0, 0, 0, 0);
        add_row(tcw_pkg::OP_PUT, 8'h41, 0, 10, 2, 1, 1, 0, 0, 11, 2);
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 1, 0, 0, 0, 1, 0, 0, 11, 2);
        // Backspace on the top row works without a mark.
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 0, 4, 0, 0, 1, 0, 0, 3, 0);
        add_row(tcw_pkg::OP_READ, 8'h00, 0, 3, 0, 0, 1, tcw_pkg::CHAR_BLANK, RESET_ATTR, 3, 0);
        add_row(tcw_pkg::OP_READ, 8'hFF, 0, 10, 2, 1, 1, 8'h41, RESET_ATTR, 3, 0);
        add_row(tcw_pkg::OP_PUT, 8'h42, 1, 0, 0, 0, 1, 0, 0, 4, 0);
        add_row(tcw_pkg::OP_CLEAR, 8'h00, 0, 0, 0, 1, 1, 0, 0, 0, 0);
        // Out-of-range position saturates to the last cell.
        add_row(tcw_pkg::OP_READ, 8'h00, 0, 127, 31, 0, 1, tcw_pkg::CHAR_BLANK, RESET_ATTR,
                0, 0);
        // Newline and a character on the last cell both scroll.
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_NEWLINE, 0, 79, 24, 0, 1, 0, 0, 0, 24);
        add_row(tcw_pkg::OP_PUT, 8'hFF, 0, 79, 24, 0, 1, 0, 0, 0, 24);
        add_row(tcw_pkg::OP_READ, 8'h00, 0, 79, 23, 0, 1, 8'hFF, RESET_ATTR, 0, 24);
        add_row(tcw_pkg::OP_READ, 8'h00, 0, 79, 24, 0, 1, tcw_pkg::CHAR_BLANK, RESET_ATTR,
                0, 24);
        add_row(tcw_pkg::OP_PUT, 8'h00, 1, 0, 0, 1, 1, 0, 0, 1, 24);
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 1, 0, 0, 0, 1, 0, 0, 0, 24);
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_NEWLINE, 1, 0, 0, 0, 1, 0, 0, 0, 24);
        add_row(tcw_pkg::OP_NOP, 8'hFF, 1, 127, 31, 1, 1, 0, 0, 0, 24);
        add_row(tcw_pkg::OP_CLEAR, 8'h00, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        // With a mark set, backspace at column 0 wraps to the row above.
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_BACKSPACE, 0, 0, 5, 0, 1, 0, 0, 79, 4);
        add_row(tcw_pkg::OP_PUT, 8'h5A, 1, 0, 0, 0, 1, 0, 0, 0, 5);
        add_row(tcw_pkg::OP_READ, 8'h00, 1, 0, 0, 0, 1, tcw_pkg::CHAR_BLANK, RESET_ATTR, 0, 5);
        add_row(tcw_pkg::OP_READ, 8'h00, 0, 79, 4, 0, 1, 8'h5A, RESET_ATTR, 0, 5);
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_NEWLINE, 1, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(tcw_pkg::OP_PUT, 8'h7E, 0, 40, 12, 0, 0, 0, 0, 0, 0);

        foreach (directed[i]) send_request(directed[i].req, directed[i].known, directed[i].rsp);

        // Random phases, each under its own colour setting, the extremes first.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin bg = 4'h0; fg = 4'h0; end
                1: begin bg = 4'hF; fg = 4'hF; end
                2: begin bg = 4'h0; fg = 4'hF; end
                3: begin bg = 4'hF; fg = 4'h0; end
                default: begin
                    bg = CLR_W'($urandom_range(0, 15));
                    fg = CLR_W'($urandom_range(0, 15));
                end
            endcase
            write_colours(bg, fg);
            repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("** text_console_writer: PASSED **");
        end else begin
            $display("** text_console_writer: FAILED **");
        end
        $finish;
    end

    // Reply side: ready toggles with random gaps.
    initial begin
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = idle_gap(ready_calm);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Reply checker: each accepted reply against the oldest expectation.
    always @(posedge clk) begin
        t_console_rsp want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch("unexpected reply, cursor row", int'(rsp_ch.cursor_row), 0);
            end else begin
                want = pending_replies.pop_front();
                if (rsp_ch.cell_char !== want.ch)
                    flag_mismatch("cell_char", int'(rsp_ch.cell_char), int'(want.ch));
                if (rsp_ch.cell_attr !== want.attr)
                    flag_mismatch("cell_attr", int'(rsp_ch.cell_attr), int'(want.attr));
                if (rsp_ch.cursor_col !== want.col)
                    flag_mismatch("cursor_col", int'(rsp_ch.cursor_col), int'(want.col));
                if (rsp_ch.cursor_row !== want.row)
                    flag_mismatch("cursor_row", int'(rsp_ch.cursor_row), int'(want.row));
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no request or reply moved for %0d cycles", QUIET_LIMIT);
            $display("** text_console_writer: FAILED **");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_ram.sv
hdl/tcw_front.sv
hdl/tcw_queue.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
sim/tb_text_console_writer.sv
